### rtl/core/nmea_rmc_sentence_parser_top_assert.svh
// assertion macros for the nmea rmc sentence parser
`ifndef NMEA_RMC_SENTENCE_PARSER_TOP_ASSERT_SVH
`define NMEA_RMC_SENTENCE_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define NRMC_ASSERT_IMPLY(lbl, clk, rstn, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error("assertion failed");
`define NRMC_ASSERT_NEXT(lbl, clk, rstn, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define NRMC_ASSERT_IMPLY(lbl, clk, rstn, cond, prop)
`define NRMC_ASSERT_NEXT(lbl, clk, rstn, cond, prop)
`endif

`endif

### rtl/core/nrmc_pkg.sv
// shared types, constants and functions of the nmea rmc sentence parser
package nrmc_pkg;

    localparam int MAX_SENTENCE_DEF = 128;
    localparam int FIELD_CHARS_DEF  = 16;
    localparam int TIME_CHARS       = 10;
    localparam int HEADER_LEN       = 6;
    localparam int CIF_W            = 5;
    localparam int LEN_W            = 8;
    localparam int TDATA_W          = 40;
    localparam int TUSER_W          = 2;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;

    localparam logic [3:0] FIELD_FIRST = 4'd1;
    localparam logic [3:0] FIELD_LAST  = 4'd9;
    localparam logic [3:0] FIELD_SAT   = 4'd15;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_HEADER = 2'd1,
        MODE_FIELDS = 2'd2,
        MODE_STAR   = 2'd3
    } nrmc_mode_t;

    typedef enum logic [1:0] {
        KIND_CHAR         = 2'd0,
        KIND_FIELD_END    = 2'd1,
        KIND_SENTENCE_END = 2'd2
    } nrmc_kind_t;

    typedef struct packed {
        nrmc_kind_t  kind;
        logic [3:0]  field_number;
        logic [7:0]  char_value;
        logic [3:0]  char_index;
        logic        checksum_present;
        logic        checksum_match;
        logic [7:0]  checksum_received;
        logic [7:0]  checksum_computed;
        logic        too_long;
        logic        last;
    } nrmc_result_t;

    typedef struct packed {
        logic [1:0]   count;
        nrmc_result_t r0;
        nrmc_result_t r1;
    } nrmc_push_t;

    function automatic logic [7:0] header_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h47;
            3'd1:    c = 8'h4e;
            3'd2:    c = 8'h52;
            3'd3:    c = 8'h4d;
            3'd4:    c = 8'h43;
            3'd5:    c = CH_COMMA;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // bit 4 set marks a non-hex byte
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] d;
        priority if (b >= 8'h30 && b <= 8'h39) begin
            d = {1'b0, 4'(b - 8'h30)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d = {1'b0, 4'(b - 8'h37)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d = {1'b0, 4'(b - 8'h57)};
        end else begin
            d = 5'h10;
        end
        return d;
    endfunction

endpackage

### rtl/core/nmea_rmc_sentence_parser_top.sv
// top level of the nmea rmc sentence parser
// Takes one received byte per cycle on the slave side, while the result queue has room, and
// reports the fields of $GNRMC sentences on the master side. A byte goes from the input
// register through the parser into a two-entry result queue; the parser state updates in the
// cycle the queue is written, so a new byte enters every cycle while results drain. Most bytes
// give zero or one result; a line feed that closes field 1 to 9 gives two (field end, then
// sentence end), and the queue depth of two lets it enter as long as the master side takes
// a result per cycle. With the master side stalled, the input holds once the queue is full.
`include "nmea_rmc_sentence_parser_top_assert.svh"

module nmea_rmc_sentence_parser_top #(
    parameter int MAX_SENTENCE = nrmc_pkg::MAX_SENTENCE_DEF,
    parameter int FIELD_CHARS  = nrmc_pkg::FIELD_CHARS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // field_number, char_value, char_index, checksum_present, checksum_match,
    // checksum_received, checksum_computed, too_long, zero fill
    output logic [nrmc_pkg::TDATA_W-1:0]  m_tdata,
    output logic [nrmc_pkg::TUSER_W-1:0]  m_tuser,   // kind
    output logic                          m_tlast
);

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_byte_reg;
    logic                   fire;
    logic [1:0]             room;
    nrmc_pkg::nrmc_push_t   push;
    nrmc_pkg::nrmc_result_t head;

    assign fire     = in_valid_reg && (push.count <= room);
    assign s_tready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    nrmc_parse #(
        .MAX_SENTENCE (MAX_SENTENCE),
        .FIELD_CHARS  (FIELD_CHARS)
    ) u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .rx_byte (in_byte_reg),
        .push    (push)
    );

    nrmc_out_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_en  (fire),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    assign m_tdata = {5'b0, head.too_long, head.checksum_computed, head.checksum_received,
                      head.checksum_match, head.checksum_present, head.char_index,
                      head.char_value, head.field_number};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    `NRMC_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !fire, in_valid_reg && $stable(in_byte_reg))

endmodule

### rtl/core/nrmc_parse.sv
// sentence state and per-byte result logic
`include "nmea_rmc_sentence_parser_top_assert.svh"

module nrmc_parse #(
    parameter int MAX_SENTENCE = nrmc_pkg::MAX_SENTENCE_DEF,
    parameter int FIELD_CHARS  = nrmc_pkg::FIELD_CHARS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic [7:0]          rx_byte,
    output nrmc_pkg::nrmc_push_t push
);

    nrmc_pkg::nrmc_mode_t mode_reg, mode_next;
    logic [2:0]                  hp_reg, hp_next;
    logic [3:0]                  fc_reg, fc_next;
    logic [nrmc_pkg::CIF_W-1:0]  cif_reg, cif_next;
    logic [7:0]                  xor_reg, xor_next;
    logic                        star_reg, star_next;
    logic [1:0]                  hdc_reg, hdc_next;
    logic [7:0]                  hex_reg, hex_next;
    logic                        bad_reg, bad_next;
    logic [nrmc_pkg::LEN_W-1:0]  len_reg, len_next;
    logic                        ovf_reg, ovf_next;

    nrmc_pkg::nrmc_result_t fe, se, ch;
    logic                       in_range;
    logic                       present;
    logic [4:0]                 digit;
    logic [nrmc_pkg::CIF_W-1:0] limit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= nrmc_pkg::MODE_IDLE;
            hp_reg   <= '0;
            fc_reg   <= '0;
            cif_reg  <= '0;
            xor_reg  <= '0;
            star_reg <= 1'b0;
            hdc_reg  <= '0;
            hex_reg  <= '0;
            bad_reg  <= 1'b0;
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
        end else if (fire) begin
            mode_reg <= mode_next;
            hp_reg   <= hp_next;
            fc_reg   <= fc_next;
            cif_reg  <= cif_next;
            xor_reg  <= xor_next;
            star_reg <= star_next;
            hdc_reg  <= hdc_next;
            hex_reg  <= hex_next;
            bad_reg  <= bad_next;
            len_reg  <= len_next;
            ovf_reg  <= ovf_next;
        end
    end

    always_comb begin
        in_range = (fc_reg >= nrmc_pkg::FIELD_FIRST) && (fc_reg <= nrmc_pkg::FIELD_LAST);
        present  = star_reg && (hdc_reg == 2'd2) && !bad_reg;
        digit    = nrmc_pkg::hex_digit(rx_byte);
        limit    = (fc_reg == nrmc_pkg::FIELD_FIRST) ?
                   nrmc_pkg::CIF_W'(nrmc_pkg::TIME_CHARS) : nrmc_pkg::CIF_W'(FIELD_CHARS);

        fe              = '0;
        fe.kind         = nrmc_pkg::KIND_FIELD_END;
        fe.field_number = fc_reg;
        fe.last         = 1'b1;

        se                   = '0;
        se.kind              = nrmc_pkg::KIND_SENTENCE_END;
        se.checksum_present  = present;
        se.checksum_match    = present && (hex_reg == xor_reg);
        se.checksum_received = present ? hex_reg : 8'h00;
        se.checksum_computed = xor_reg;
        se.too_long          = ovf_reg;
        se.last              = 1'b1;

        ch              = '0;
        ch.kind         = nrmc_pkg::KIND_CHAR;
        ch.field_number = fc_reg;
        ch.char_value   = rx_byte;
        ch.char_index   = cif_reg[3:0];
        ch.last         = 1'b1;

        mode_next = mode_reg;
        hp_next   = hp_reg;
        fc_next   = fc_reg;
        cif_next  = cif_reg;
        xor_next  = xor_reg;
        star_next = star_reg;
        hdc_next  = hdc_reg;
        hex_next  = hex_reg;
        bad_next  = bad_reg;
        len_next  = len_reg;
        ovf_next  = ovf_reg;
        push      = '0;

        priority if (rx_byte == nrmc_pkg::CH_DOLLAR) begin
            mode_next = nrmc_pkg::MODE_HEADER;
            hp_next   = '0;
            fc_next   = '0;
            cif_next  = '0;
            xor_next  = '0;
            star_next = 1'b0;
            hdc_next  = '0;
            hex_next  = '0;
            bad_next  = 1'b0;
            len_next  = nrmc_pkg::LEN_W'(1);
            ovf_next  = 1'b0;
        end else if (rx_byte == nrmc_pkg::CH_CR) begin
            mode_next = mode_reg;
        end else if (rx_byte == nrmc_pkg::CH_LF) begin
            if (mode_reg == nrmc_pkg::MODE_FIELDS && in_range) begin
                push.count = 2'd2;
                push.r0    = fe;
                push.r0.last = 1'b0;
                push.r1    = se;
            end else if (mode_reg == nrmc_pkg::MODE_FIELDS ||
                         mode_reg == nrmc_pkg::MODE_STAR) begin
                push.count = 2'd1;
                push.r0    = se;
            end
            mode_next = nrmc_pkg::MODE_IDLE;
        end else if (mode_reg == nrmc_pkg::MODE_IDLE) begin
            mode_next = mode_reg;
        end else if (len_reg >= nrmc_pkg::LEN_W'(MAX_SENTENCE)) begin
            ovf_next = 1'b1;
        end else begin
            len_next = nrmc_pkg::LEN_W'(len_reg + 1'b1);
            unique case (mode_reg)
                nrmc_pkg::MODE_HEADER: begin
                    if (hp_reg < 3'(nrmc_pkg::HEADER_LEN) &&
                        rx_byte == nrmc_pkg::header_char(hp_reg)) begin
                        xor_next = xor_reg ^ rx_byte;
                        hp_next  = 3'(hp_reg + 1'b1);
                        if (hp_reg == 3'(nrmc_pkg::HEADER_LEN - 1)) begin
                            mode_next = nrmc_pkg::MODE_FIELDS;
                            fc_next   = nrmc_pkg::FIELD_FIRST;
                            cif_next  = '0;
                        end
                    end else begin
                        mode_next = nrmc_pkg::MODE_IDLE;
                    end
                end
                nrmc_pkg::MODE_STAR: begin
                    if (hdc_reg < 2'd2 && !digit[4]) begin
                        hex_next = {hex_reg[3:0], digit[3:0]};
                        hdc_next = 2'(hdc_reg + 1'b1);
                    end else begin
                        bad_next = 1'b1;
                    end
                end
                nrmc_pkg::MODE_FIELDS: begin
                    priority if (rx_byte == nrmc_pkg::CH_STAR) begin
                        star_next = 1'b1;
                        mode_next = nrmc_pkg::MODE_STAR;
                        if (in_range) begin
                            push.count = 2'd1;
                            push.r0    = fe;
                        end
                    end else if (rx_byte == nrmc_pkg::CH_COMMA) begin
                        xor_next = xor_reg ^ rx_byte;
                        if (in_range) begin
                            push.count = 2'd1;
                            push.r0    = fe;
                        end
                        if (fc_reg < nrmc_pkg::FIELD_SAT) begin
                            fc_next = 4'(fc_reg + 1'b1);
                        end
                        cif_next = '0;
                    end else begin
                        xor_next = xor_reg ^ rx_byte;
                        if (in_range && cif_reg < limit) begin
                            push.count = 2'd1;
                            push.r0    = ch;
                            cif_next   = nrmc_pkg::CIF_W'(cif_reg + 1'b1);
                        end
                    end
                end
                default: begin
                    mode_next = nrmc_pkg::MODE_IDLE;
                end
            endcase
        end
    end

    `NRMC_ASSERT_IMPLY(a_pair_order, aclk, aresetn, push.count == 2'd2, push.r0.kind == nrmc_pkg::KIND_FIELD_END && !push.r0.last && push.r1.kind == nrmc_pkg::KIND_SENTENCE_END && push.r1.last)
    `NRMC_ASSERT_NEXT(a_lf_idle, aclk, aresetn, fire && rx_byte == nrmc_pkg::CH_LF, mode_reg == nrmc_pkg::MODE_IDLE)

endmodule

### rtl/core/nrmc_out_queue.sv
// two-entry result queue feeding the master side
`include "nmea_rmc_sentence_parser_top_assert.svh"

module nrmc_out_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_en,
    input  nrmc_pkg::nrmc_push_t  push,
    output logic [1:0]            room,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output nrmc_pkg::nrmc_result_t head
);

    logic [1:0]             count_reg, count_next;
    nrmc_pkg::nrmc_result_t e0_reg, e0_next;
    nrmc_pkg::nrmc_result_t e1_reg, e1_next;
    logic                   pop;
    logic [1:0]             cnt_after;
    nrmc_pkg::nrmc_result_t head_after;
    logic [1:0]             add;

    assign m_tvalid = (count_reg != 2'd0);
    assign head     = e0_reg;
    assign pop      = m_tvalid && m_tready;
    assign room     = 2'(2'd2 - count_reg + {1'b0, pop});

    always_comb begin
        cnt_after  = 2'(count_reg - {1'b0, pop});
        head_after = pop ? e1_reg : e0_reg;
        add        = push_en ? push.count : 2'd0;
        e0_next    = head_after;
        e1_next    = e1_reg;
        if (push_en) begin
            unique case (cnt_after)
                2'd0: begin
                    e0_next = push.r0;
                    e1_next = push.r1;
                end
                2'd1: begin
                    e1_next = push.r0;
                end
                default: begin
                    e1_next = e1_reg;
                end
            endcase
        end
        count_next = 2'(cnt_after + add);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    `NRMC_ASSERT_IMPLY(a_count_max, aclk, aresetn, 1'b1, count_reg != 2'd3)
    `NRMC_ASSERT_IMPLY(a_no_overfill, aclk, aresetn, push_en, push.count <= room)

endmodule
